[rtl/becang_pkg.sv]
package becang_pkg;

  typedef logic [1:0] cfg_idx_t;

  localparam cfg_idx_t REG_POINT_AZ = 2'd0;
  localparam cfg_idx_t REG_POINT_EL = 2'd1;
  localparam cfg_idx_t REG_HALF_H   = 2'd2;
  localparam cfg_idx_t REG_HALF_V   = 2'd3;

  localparam logic signed [35:0] PI_Q       = 36'sd3373259426;
  localparam logic signed [35:0] HALF_PI_Q  = 36'sd1686629713;
  localparam logic signed [35:0] INV_GAIN_Q = 36'sd652032874;
  localparam logic signed [37:0] ONE_Q      = 38'sd1073741824;
  localparam logic [36:0]        SQRT_LIMIT = 37'h3_FFFF_FFFF;
  localparam logic signed [17:0] AZ_LIMIT   = 18'sd25736;
  localparam logic signed [17:0] EL_LIMIT   = 18'sd12868;

  // arctan(2^-i) in Q.30
  function automatic logic signed [35:0] atan_q30(input int unsigned i);
    logic signed [35:0] v;
    case (i)
      0:  v = 36'sd843314857;
      1:  v = 36'sd497837829;
      2:  v = 36'sd263043836;
      3:  v = 36'sd133525159;
      4:  v = 36'sd67021686;
      5:  v = 36'sd33543515;
      6:  v = 36'sd16775850;
      7:  v = 36'sd8388437;
      8:  v = 36'sd4194282;
      9:  v = 36'sd2097149;
      10: v = 36'sd1048575;
      11: v = 36'sd524287;
      12: v = 36'sd262143;
      13: v = 36'sd131071;
      14: v = 36'sd65535;
      15: v = 36'sd32767;
      16: v = 36'sd16383;
      17: v = 36'sd8191;
      18: v = 36'sd4095;
      19: v = 36'sd2047;
      20: v = 36'sd1023;
      21: v = 36'sd511;
      22: v = 36'sd255;
      23: v = 36'sd127;
      24: v = 36'sd63;
      25: v = 36'sd31;
      26: v = 36'sd15;
      27: v = 36'sd8;
      28: v = 36'sd4;
      29: v = 36'sd2;
      30: v = 36'sd1;
      default: v = 36'sd0;
    endcase
    return v;
  endfunction

endpackage

[rtl/beam_ellipse_contour_angles.sv]
// Contour of a beam ellipse in azimuth/elevation. Each phase transfer yields one
// contour point; one point enters per cycle while the output is not stalled. It
// holds a sin/cos and an atan2 CORDIC chain of CORDIC_STEPS stages (at most 32)
// and a 32-stage square root. A stalled output freezes the
// whole pipeline. Write configuration only while no point is in flight.
module beam_ellipse_contour_angles #(
  parameter int ANGLE_BITS   = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  becang_pkg::cfg_idx_t   cfg_index_i,
  input  logic [15:0]            cfg_data_i,
  input  logic                   valid_i,
  output logic                   stall_o,
  input  logic [15:0]            phase_i,
  output logic                   valid_o,
  input  logic                   stall_i,
  output logic signed [15:0]     azimuth_o,
  output logic signed [14:0]     elevation_o,
  output logic                   off_sphere_o
);
  import becang_pkg::*;

  localparam int N    = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
  localparam int KEEP = (ANGLE_BITS < 16) ? ANGLE_BITS : 16;
  localparam logic [15:0] PHASE_MASK = 16'(~((32'd1 << (16 - KEEP)) - 32'd1));
  localparam int LAT  = 2 * N + 40;

  logic signed [15:0] point_az_q;
  logic signed [14:0] point_el_q;
  logic [15:0]        half_h_q, half_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_az_q <= '0;
      point_el_q <= '0;
      half_h_q   <= 16'd572;
      half_v_q   <= 16'd572;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_POINT_AZ: point_az_q <= cfg_data_i;
        REG_POINT_EL: point_el_q <= cfg_data_i[14:0];
        REG_HALF_H:   half_h_q   <= cfg_data_i;
        REG_HALF_V:   half_v_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic           en;
  logic [LAT-1:0] vld_q;

  assign en      = !vld_q[LAT-1] || !stall_i;
  assign stall_o = !en;
  assign valid_o = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], valid_i};
    end
  end

  // phase to Q.30 radians
  logic signed [15:0] ps;
  logic signed [51:0] ph_prod;
  logic signed [35:0] ang_q;

  assign ps      = $signed(phase_i & PHASE_MASK);
  assign ph_prod = 52'(ps) * 52'(PI_Q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      ang_q <= 36'(ph_prod >>> 15);
    end
  end

  // sin/cos lanes: 0 azimuth, 1 elevation, 2 phase
  logic signed [35:0] rx_q [N+1][3];
  logic signed [35:0] ry_q [N+1][3];
  logic signed [35:0] rz_q [N+1][3];
  logic [2:0]         rn_q [N+1];

  logic signed [35:0] a_in [3];
  assign a_in[0] = 36'($signed({point_az_q, 17'd0}));
  assign a_in[1] = 36'($signed({point_el_q, 17'd0}));
  assign a_in[2] = ang_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        rx_q[0][l] <= INV_GAIN_Q;
        ry_q[0][l] <= '0;
        if (a_in[l] > HALF_PI_Q) begin
          rz_q[0][l] <= a_in[l] - PI_Q;
          rn_q[0][l] <= 1'b1;
        end else if (a_in[l] < -HALF_PI_Q) begin
          rz_q[0][l] <= a_in[l] + PI_Q;
          rn_q[0][l] <= 1'b1;
        end else begin
          rz_q[0][l] <= a_in[l];
          rn_q[0][l] <= 1'b0;
        end
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    logic signed [35:0] xn [3];
    logic signed [35:0] yn [3];
    logic signed [35:0] zn [3];
    always_comb begin
      for (int l = 0; l < 3; l++) begin
        if (rz_q[i][l] >= 0) begin
          xn[l] = rx_q[i][l] - (ry_q[i][l] >>> i);
          yn[l] = ry_q[i][l] + (rx_q[i][l] >>> i);
          zn[l] = rz_q[i][l] - atan_q30(i);
        end else begin
          xn[l] = rx_q[i][l] + (ry_q[i][l] >>> i);
          yn[l] = ry_q[i][l] - (rx_q[i][l] >>> i);
          zn[l] = rz_q[i][l] + atan_q30(i);
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        rx_q[i+1] <= xn;
        ry_q[i+1] <= yn;
        rz_q[i+1] <= zn;
        rn_q[i+1] <= rn_q[i];
      end
    end
  end

  // sign fix and products
  logic signed [35:0] sin_q, cos_e, sin_e, sin_p, cos_p;
  assign sin_q = rn_q[N][0] ? -ry_q[N][0] : ry_q[N][0];
  assign cos_e = rn_q[N][1] ? -rx_q[N][1] : rx_q[N][1];
  assign sin_e = rn_q[N][1] ? -ry_q[N][1] : ry_q[N][1];
  assign sin_p = rn_q[N][2] ? -ry_q[N][2] : ry_q[N][2];
  assign cos_p = rn_q[N][2] ? -rx_q[N][2] : rx_q[N][2];

  logic signed [32:0] sy_op, sz_op;
  assign sy_op = $signed({1'b0, half_h_q, 15'd0});
  assign sz_op = $signed({1'b0, half_v_q, 15'd0});

  logic signed [65:0] p1_q, p2_q, p3_q;
  logic signed [35:0] se_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q <= 66'(33'(sin_q)) * 66'(33'(cos_e));
      p2_q <= 66'(sy_op) * 66'(33'(cos_p));
      p3_q <= 66'(sz_op) * 66'(33'(sin_p));
      se_q <= sin_e;
    end
  end

  logic signed [35:0] yp_q, zp_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      yp_q <= -36'(p1_q >>> 30) + 36'(p2_q >>> 30);
      zp_q <= se_q + 36'(p3_q >>> 30);
    end
  end

  logic [32:0]        ay, az_mag;
  logic [65:0]        ysq_full, zsq_full;
  logic [35:0]        ysq_q, zsq_q;
  logic signed [35:0] yp3_q, zp3_q;

  assign ay       = 33'(yp_q < 0 ? -yp_q : yp_q);
  assign az_mag   = 33'(zp_q < 0 ? -zp_q : zp_q);
  assign ysq_full = 66'(ay) * 66'(ay);
  assign zsq_full = 66'(az_mag) * 66'(az_mag);

  always_ff @(posedge clk_i) begin
    if (en) begin
      ysq_q <= 36'(ysq_full >> 30);
      zsq_q <= 36'(zsq_full >> 30);
      yp3_q <= yp_q;
      zp3_q <= zp_q;
    end
  end

  // radicands, magnitude taken and saturated
  logic signed [37:0] r_s, w_s;
  logic [36:0]        r_abs, w_abs;
  assign r_s   = ONE_Q - $signed({2'b0, ysq_q}) - $signed({2'b0, zsq_q});
  assign w_s   = ONE_Q - $signed({2'b0, zsq_q});
  assign r_abs = 37'(r_s < 0 ? -r_s : r_s);
  assign w_abs = 37'(w_s < 0 ? -w_s : w_s);

  logic [33:0]        rad_q  [33][2];
  logic [33:0]        rem_q  [33][2];
  logic [31:0]        root_q [33][2];
  logic signed [35:0] syp_q  [33];
  logic signed [35:0] szp_q  [33];
  logic               soff_q [33];

  always_ff @(posedge clk_i) begin
    if (en) begin
      rad_q[0][0]  <= (r_abs > SQRT_LIMIT) ? SQRT_LIMIT[33:0] : r_abs[33:0];
      rad_q[0][1]  <= (w_abs > SQRT_LIMIT) ? SQRT_LIMIT[33:0] : w_abs[33:0];
      rem_q[0][0]  <= '0;
      rem_q[0][1]  <= '0;
      root_q[0][0] <= '0;
      root_q[0][1] <= '0;
      syp_q[0]     <= yp3_q;
      szp_q[0]     <= zp3_q;
      soff_q[0]    <= r_s < 0;
    end
  end

  // one result bit per stage, most significant first
  for (genvar k = 0; k < 32; k++) begin : g_sqrt
    logic [63:0] n    [2];
    logic [35:0] trem [2];
    logic [35:0] trial[2];
    logic [33:0] rem_n [2];
    logic [31:0] root_n[2];
    always_comb begin
      for (int l = 0; l < 2; l++) begin
        n[l]     = {rad_q[k][l], 30'd0};
        trem[l]  = {rem_q[k][l], n[l][2*(31-k)+1 -: 2]};
        trial[l] = {2'b00, root_q[k][l], 2'b01};
        if (trem[l] >= trial[l]) begin
          rem_n[l]  = 34'(trem[l] - trial[l]);
          root_n[l] = {root_q[k][l][30:0], 1'b1};
        end else begin
          rem_n[l]  = trem[l][33:0];
          root_n[l] = {root_q[k][l][30:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        rad_q[k+1]  <= rad_q[k];
        rem_q[k+1]  <= rem_n;
        root_q[k+1] <= root_n;
        syp_q[k+1]  <= syp_q[k];
        szp_q[k+1]  <= szp_q[k];
        soff_q[k+1] <= soff_q[k];
      end
    end
  end

  // atan2 lanes: 0 azimuth, 1 elevation
  logic signed [37:0] vx_q [N+1][2];
  logic signed [37:0] vy_q [N+1][2];
  logic signed [33:0] vz_q [N+1][2];
  logic               voff_q [N+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      vx_q[0][0] <= $signed({6'd0, root_q[32][0]});
      vx_q[0][1] <= $signed({6'd0, root_q[32][1]});
      vy_q[0][0] <= 38'(syp_q[32]);
      vy_q[0][1] <= 38'(szp_q[32]);
      vz_q[0][0] <= '0;
      vz_q[0][1] <= '0;
      voff_q[0]  <= soff_q[32];
    end
  end

  for (genvar j = 0; j < N; j++) begin : g_vec
    logic signed [37:0] xn [2];
    logic signed [37:0] yn [2];
    logic signed [33:0] zn [2];
    always_comb begin
      for (int l = 0; l < 2; l++) begin
        if (vy_q[j][l] >= 0) begin
          xn[l] = vx_q[j][l] + (vy_q[j][l] >>> j);
          yn[l] = vy_q[j][l] - (vx_q[j][l] >>> j);
          zn[l] = vz_q[j][l] + 34'(atan_q30(j));
        end else begin
          xn[l] = vx_q[j][l] - (vy_q[j][l] >>> j);
          yn[l] = vy_q[j][l] + (vx_q[j][l] >>> j);
          zn[l] = vz_q[j][l] - 34'(atan_q30(j));
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        vx_q[j+1]   <= xn;
        vy_q[j+1]   <= yn;
        vz_q[j+1]   <= zn;
        voff_q[j+1] <= voff_q[j];
      end
    end
  end

  // round half up to Q2.13 (azimuth) and Q1.13 (elevation) and clamp
  logic signed [34:0] az_sum, el_sum;
  logic signed [17:0] az_t, el_t, az_c, el_c;

  assign az_sum = -35'(vz_q[N][0]) + 35'sd65536;
  assign el_sum = 35'(vz_q[N][1]) + 35'sd65536;
  assign az_t   = 18'(az_sum >>> 17);
  assign el_t   = 18'(el_sum >>> 17);
  assign az_c   = (az_t > AZ_LIMIT) ? AZ_LIMIT : ((az_t < -AZ_LIMIT) ? -AZ_LIMIT : az_t);
  assign el_c   = (el_t > EL_LIMIT) ? EL_LIMIT : ((el_t < -EL_LIMIT) ? -EL_LIMIT : el_t);

  always_ff @(posedge clk_i) begin
    if (en) begin
      azimuth_o    <= az_c[15:0];
      elevation_o  <= el_c[14:0];
      off_sphere_o <= voff_q[N];
    end
  end

endmodule

[rtl/becang_assert.sv]
module becang_assert (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 stall_o,
  input logic                 valid_o,
  input logic                 stall_i,
  input logic signed [15:0]   azimuth_o,
  input logic signed [14:0]   elevation_o,
  input logic                 off_sphere_o
);

  // input side stalls only behind a held result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> valid_o && stall_i)
    else $error("input stalled without a held result");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(azimuth_o) && $stable(elevation_o)
      && $stable(off_sphere_o))
    else $error("stalled result changed");

  a_az_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> azimuth_o <= 16'sd25736 && azimuth_o >= -16'sd25736)
    else $error("azimuth out of range");

  a_el_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> elevation_o <= 15'sd12868 && elevation_o >= -15'sd12868)
    else $error("elevation out of range");

endmodule

bind beam_ellipse_contour_angles becang_assert u_becang_assert (.*);
